>>> design/xds_pkg.sv
// Shared types, sizes and codes for the XOR distance shortlist.
// Used by xds_cell and xor_distance_shortlist_core; no dependencies.
package xds_pkg;

	localparam int ENTRIES  = 16;
	localparam int ID_BITS  = 64;
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int FIELD_W  = 64;
	localparam int CAP_W    = 5;
	localparam int STATUS_W = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	localparam logic CFG_TARGET_ID = 1'b0;
	localparam logic CFG_CAPACITY  = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_TAKE_NEW,
		CELL_TAKE_PREV,
		CELL_TAKE_NEXT
	} cell_cmd_t;

	typedef struct packed {
		logic      cmp_en;
		logic      in_use;
		cell_cmd_t cmd;
	} cell_ctrl_t;

	typedef struct packed {
		logic [ID_BITS-1:0] distance;
		logic [FIELD_W-1:0] addr;
	} entry_t;

endpackage

>>> design/xds_cell.sv
// One shortlist cell: holds an entry, compares it against the broadcast distance,
// and loads from itself, the new item, or either neighbor. Depends on xds_pkg.
module xds_cell (
	input  logic                clk,
	input  xds_pkg::cell_ctrl_t ctrl,
	input  xds_pkg::entry_t     new_entry,
	input  xds_pkg::entry_t     prev_entry,
	input  xds_pkg::entry_t     next_entry,
	output xds_pkg::entry_t     entry,
	output logic                gt,
	output logic                eq
);

	xds_pkg::entry_t entry_q;
	logic            gt_q;
	logic            eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			gt_q <= ctrl.in_use && (entry_q.distance > new_entry.distance);
			eq_q <= ctrl.in_use && (entry_q.distance == new_entry.distance);
		end
		case (ctrl.cmd)
			xds_pkg::CELL_TAKE_NEW:  entry_q <= new_entry;
			xds_pkg::CELL_TAKE_PREV: entry_q <= prev_entry;
			xds_pkg::CELL_TAKE_NEXT: entry_q <= next_entry;
			default:                 entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign gt    = gt_q;
	assign eq    = eq_q;

endmodule

>>> design/xor_distance_shortlist_core.sv
// XOR distance shortlist: a sorted row of entry cells ordered by peer_id ^ target_id.
// Top level; depends on xds_pkg and xds_cell.
//
// Each command passes through a compare state and an apply state: start is taken when busy
// is low, the next cycle all cells compare their distance with the new one in parallel, and
// in the apply state every cell shifts or loads in one step and the result is registered;
// it is on the result ports in the cycle after that. result_valid is high for exactly one cycle
// per command and cannot be held off, so the receiver must take it then. busy is high
// in the compare and apply states after a command is taken; the command rate is set by this
// compare-then-shift sequence. Configuration writes are taken at any cycle and should
// be made while no command is in flight.
module xor_distance_shortlist_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [xds_pkg::FIELD_W-1:0]      cfg_data,
	input  logic                             start,
	output logic                             busy,
	input  logic                             opcode,
	input  logic [xds_pkg::FIELD_W-1:0]      peer_id,
	input  logic [xds_pkg::FIELD_W-1:0]      peer_address,
	output logic                             result_valid,
	output logic [xds_pkg::STATUS_W-1:0]     status,
	output logic [xds_pkg::FIELD_W-1:0]      out_distance,
	output logic [xds_pkg::FIELD_W-1:0]      out_address,
	output logic                             target_found,
	output logic [xds_pkg::CAP_W-1:0]        fill_count
);

	localparam int N = xds_pkg::ENTRIES;
	localparam int CW = xds_pkg::CNT_W;
	localparam int LW = (CW > xds_pkg::CAP_W) ? CW : xds_pkg::CAP_W;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_CMP   = 2'd1;
	localparam logic [1:0] PH_APPLY = 2'd2;

	logic [1:0]                        phase_q;
	logic [xds_pkg::FIELD_W-1:0]       target_q;
	logic [xds_pkg::CAP_W-1:0]         cap_q;
	logic [CW-1:0]                     count_q;
	logic                              op_q;
	xds_pkg::entry_t                   new_q;

	xds_pkg::cell_ctrl_t               ctrl   [N];
	xds_pkg::entry_t                   cell_e [N];
	logic [N-1:0]                      gt_v;
	logic [N-1:0]                      eq_v;
	logic [N-1:0]                      gm;

	logic                              accept;
	logic [LW-1:0]                     cap_eff;
	logic                              room;
	logic                              dup;
	logic                              insert_ok;
	logic                              pop_ok;
	logic [CW-1:0]                     m;

	assign busy   = (phase_q != PH_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cap_eff = LW'(cap_q);
		if (cap_q == '0)
			cap_eff = LW'(1);
		if (LW'(cap_q) > LW'(N))
			cap_eff = LW'(N);
	end

	assign room      = LW'(count_q) < cap_eff;
	assign dup       = |eq_v;
	assign insert_ok = (op_q == xds_pkg::OP_INSERT) && !dup && (room || (count_q != '0 && |gt_v));
	assign pop_ok    = (op_q == xds_pkg::OP_POP) && (count_q != '0);
	assign m         = room ? count_q : count_q - CW'(1);

	always_comb begin
		for (int i = 0; i < N; i++) begin
			gm[i] = gt_v[i] && (CW'(i) < m);
			ctrl[i].cmp_en = (phase_q == PH_CMP);
			ctrl[i].in_use = (CW'(i) < count_q);
			ctrl[i].cmd    = xds_pkg::CELL_HOLD;
		end
		if (phase_q == PH_APPLY) begin
			for (int i = 0; i < N; i++) begin
				if (pop_ok) begin
					ctrl[i].cmd = xds_pkg::CELL_TAKE_NEXT;
				end else if (insert_ok && CW'(i) <= m && !(CW'(i) < m && !gm[i])) begin
					if (i == 0)
						ctrl[i].cmd = xds_pkg::CELL_TAKE_NEW;
					else if (!gm[(i == 0) ? 0 : i-1])
						ctrl[i].cmd = xds_pkg::CELL_TAKE_NEW;
					else
						ctrl[i].cmd = xds_pkg::CELL_TAKE_PREV;
				end
			end
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		xds_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[g]),
			.new_entry  (new_q),
			.prev_entry (cell_e[(g == 0) ? 0 : g-1]),
			.next_entry (cell_e[(g == N-1) ? N-1 : g+1]),
			.entry      (cell_e[g]),
			.gt         (gt_v[g]),
			.eq         (eq_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			target_q     <= '0;
			cap_q        <= xds_pkg::CAP_W'(16);
			count_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (phase_q == PH_APPLY);
			if (cfg_we) begin
				case (cfg_index)
					xds_pkg::CFG_TARGET_ID: target_q <= cfg_data;
					xds_pkg::CFG_CAPACITY:  cap_q    <= cfg_data[xds_pkg::CAP_W-1:0];
					default:                target_q <= target_q;
				endcase
			end
			case (phase_q)
				PH_IDLE: begin
					if (accept)
						phase_q <= PH_CMP;
				end
				PH_CMP: begin
					phase_q <= PH_APPLY;
				end
				PH_APPLY: begin
					phase_q <= PH_IDLE;
					if (pop_ok)
						count_q <= count_q - CW'(1);
					else if (insert_ok && room)
						count_q <= count_q + CW'(1);
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q           <= opcode;
			new_q.distance <= peer_id[xds_pkg::ID_BITS-1:0] ^ target_q[xds_pkg::ID_BITS-1:0];
			new_q.addr     <= peer_address;
		end
		if (phase_q == PH_APPLY) begin
			if (pop_ok) begin
				status       <= xds_pkg::ST_POPPED;
				out_distance <= xds_pkg::FIELD_W'(cell_e[0].distance);
				out_address  <= cell_e[0].addr;
				target_found <= (cell_e[0].distance == '0);
				fill_count   <= xds_pkg::CAP_W'(count_q - CW'(1));
			end else begin
				out_distance <= '0;
				out_address  <= '0;
				target_found <= 1'b0;
				if (op_q == xds_pkg::OP_POP) begin
					status     <= xds_pkg::ST_EMPTY;
					fill_count <= xds_pkg::CAP_W'(count_q);
				end else if (dup) begin
					status     <= xds_pkg::ST_DUPLICATE;
					fill_count <= xds_pkg::CAP_W'(count_q);
				end else if (insert_ok) begin
					status     <= xds_pkg::ST_INSERTED;
					fill_count <= room ? xds_pkg::CAP_W'(count_q + CW'(1))
						: xds_pkg::CAP_W'(count_q);
				end else begin
					status     <= xds_pkg::ST_REJECTED;
					fill_count <= xds_pkg::CAP_W'(count_q);
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(count_q) <= LW'(N))
		else $error("entry count above number of cells");

	a_result_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(phase_q) == PH_APPLY)
		else $error("result without an apply cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command taken but block not busy");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == xds_pkg::ST_POPPED) |-> count_q + CW'(1) == $past(count_q))
		else $error("pop did not remove one entry");

endmodule
